// ===== src/box_blur_3x3_stream_top_macros.svh =====
`ifndef BOX_BLUR_3X3_STREAM_TOP_MACROS_SVH
`define BOX_BLUR_3X3_STREAM_TOP_MACROS_SVH
// Assertion shorthands for the 3x3 box blur checker.

// Consequent checked in the same cycle as the antecedent.
`define BB3_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bb3_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants shared by the 3x3 box blur block and its checker.
package bb3_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int PIXEL_BITS   = 8;
  localparam int MAX_CHANNELS = 3;
  localparam int CH_FIELDS    = 3;
  localparam int PIX_W        = CH_FIELDS * PIXEL_BITS;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int IN_ROW_W = $clog2(MAX_HEIGHT + 2);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int WH_W       = 11;
  localparam int NCH_W      = 2;
  localparam int CMP_W      = WH_W + 1;

  localparam int BLUR_W   = 10;
  localparam int POS_W    = 10;
  localparam int BLUR_MAX = 3 * (2 ** PIXEL_BITS - 1);
  localparam int SUM_W    = $clog2(9 * (2 ** PIXEL_BITS - 1) + 1);

  // floor(x / 3) == (x * DIV3_MUL) >> DIV3_SHIFT for every x below 2**DIV3_SHIFT
  localparam int DIV3_SHIFT = 13;
  localparam int DIV3_MUL   = (2 ** DIV3_SHIFT) / 3 + 1;
  localparam int MUL_W      = $clog2(DIV3_MUL + 1);
  localparam int PROD_W     = SUM_W + MUL_W;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_NUM_CHANNELS = 2'd2
  } bb3_reg_t;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } bb3_act_t;

  typedef struct packed {
    logic                  action;
    logic [PIXEL_BITS-1:0] sample_ch0;
    logic [PIXEL_BITS-1:0] sample_ch1;
    logic [PIXEL_BITS-1:0] sample_ch2;
  } bb3_in_t;

  typedef struct packed {
    logic [BLUR_W-1:0] blur_ch0;
    logic [BLUR_W-1:0] blur_ch1;
    logic [BLUR_W-1:0] blur_ch2;
    logic [POS_W-1:0]  pixel_row;
    logic [POS_W-1:0]  pixel_col;
    logic              frame_end;
  } bb3_out_t;

endpackage

// ===== src/box_blur_3x3_stream_top.sv =====
`timescale 1ns / 1ps
// Streaming 3x3 box blur: line memory, window, sum, divide-by-3 and result queue.
//
// Usage:
//   Pixels enter in raster order on in_valid/in_stall/in_data (action = pixel).
//   Results trail the input by image_width+1 items; after the last pixel, send
//   image_width+1 flush transactions to drain them. A flush sent while pixels
//   are still expected is accepted and dropped; a pixel sent while draining
//   counts as a flush. frame_end marks the last result of the image.
//   Configuration (width, height, channels) goes through cfg_wr_en/cfg_index/
//   cfg_wdata while the block is idle; any valid write restarts the image.
// Timing:
//   One item per clock while in_stall is low. The line memory is read when
//   an item is accepted and written back on the next edge; back-to-back hits
//   on the same entry (width 1) are forwarded. The result of a neighborhood
//   runs through window, sum, divide and queue registers to out_valid.
//   Results queue in an 8-entry FIFO; in_stall rises while 8 results are
//   owed to the receiver, so a stalled receiver stops the input only then.
// Reset:
//   Counters and queue clear, registers return to 3/3/3. The line memory is
//   not cleared: every entry read before it is written in the image is masked.
module box_blur_3x3_stream_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bb3_pkg::bb3_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bb3_pkg::bb3_out_t                 out_data,
  input  logic                              cfg_wr_en,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bb3_pkg::*;

  typedef logic [CH_FIELDS-1:0][PIXEL_BITS-1:0] pix_t;

  typedef struct packed {
    logic             top_en;
    logic             bot_en;
    logic             left_en;
    logic             right_en;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } pos_t;

  // configuration
  logic [WH_W-1:0]  width_cfg_r;
  logic [WH_W-1:0]  height_cfg_r;
  logic [NCH_W-1:0] nch_cfg_r;
  logic [WH_W-1:0]  w_eff;
  logic [WH_W-1:0]  h_eff;
  logic [NCH_W-1:0] nch_eff;
  logic             cfg_hit;

  // raster counters
  logic [COL_W-1:0]    in_col_r, in_col_nxt;
  logic [IN_ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic [ROW_W-1:0]    out_row_r, out_row_nxt;

  // accept stage
  logic in_acc, upd, draining, is_flush, emit, col_wrap, last;
  pix_t raw, samp;
  pos_t pos;

  // line memory: {row two back, row one back} per column
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] line_rd_r;

  // window update stage
  logic             s1_vld_r;
  logic             s1_emit_r;
  logic             s1_fwd_r;
  logic [COL_W-1:0] s1_addr_r;
  pix_t             s1_samp_r;
  pos_t             s1_pos_r;
  pix_t             fwd_above_r;
  pix_t             fwd_center_r;
  pix_t             above_in;
  pix_t             center_in;
  pix_t             win_r [3][3];

  // sum stage
  logic                             s2_vld_r;
  pos_t                             s2_pos_r;
  logic [2:0]                       row_en;
  logic [2:0]                       col_en;
  logic [CH_FIELDS-1:0][SUM_W-1:0]  s2_sum;

  // divide stage
  logic                             s3_vld_r;
  pos_t                             s3_pos_r;
  logic [CH_FIELDS-1:0][SUM_W-1:0]  s3_sum_r;
  logic [CH_FIELDS-1:0][PROD_W-1:0] prod;
  bb3_out_t                         res;

  // result queue
  bb3_out_t              fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] fifo_cnt_r, fifo_cnt_nxt;
  logic [FIFO_CNT_W-1:0] cred_r, cred_nxt;
  logic                  pop;

  // ---------------------------------------------------------------- config
  assign cfg_hit = cfg_wr_en &&
                   (cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_NUM_CHANNELS});

  always_comb begin
    if (width_cfg_r == '0) begin
      w_eff = WH_W'(1);
    end else if (width_cfg_r > WH_W'(MAX_WIDTH)) begin
      w_eff = WH_W'(MAX_WIDTH);
    end else begin
      w_eff = width_cfg_r;
    end
    if (height_cfg_r == '0) begin
      h_eff = WH_W'(1);
    end else if (height_cfg_r > WH_W'(MAX_HEIGHT)) begin
      h_eff = WH_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_cfg_r;
    end
    if (nch_cfg_r == '0) begin
      nch_eff = NCH_W'(1);
    end else if (nch_cfg_r > NCH_W'(MAX_CHANNELS)) begin
      nch_eff = NCH_W'(MAX_CHANNELS);
    end else begin
      nch_eff = nch_cfg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= WH_W'(3);
      height_cfg_r <= WH_W'(3);
      nch_cfg_r    <= NCH_W'(3);
    end else if (cfg_wr_en) begin
      case (bb3_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_cfg_r  <= cfg_wdata[WH_W-1:0];
        REG_IMAGE_HEIGHT: height_cfg_r <= cfg_wdata[WH_W-1:0];
        REG_NUM_CHANNELS: nch_cfg_r    <= cfg_wdata[NCH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- accept
  assign in_stall = (cred_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign is_flush = (in_data.action == ACT_FLUSH);
  assign draining = (CMP_W'(in_row_r) >= CMP_W'(h_eff));
  // drop a flush that arrives while pixels are still expected
  assign upd      = in_acc && !(is_flush && !draining);
  assign emit     = (in_row_r >= IN_ROW_W'(2)) ||
                    ((in_row_r == IN_ROW_W'(1)) && (in_col_r != '0));
  assign col_wrap = (CMP_W'(in_col_r) + CMP_W'(1) >= CMP_W'(w_eff));

  assign raw[0] = in_data.sample_ch0;
  assign raw[1] = in_data.sample_ch1;
  assign raw[2] = in_data.sample_ch2;

  always_comb begin
    for (int k = 0; k < CH_FIELDS; k++) begin
      samp[k] = (!draining && (NCH_W'(k) < nch_eff)) ? raw[k] : '0;
    end
  end

  always_comb begin
    pos.top_en   = (out_row_r != '0);
    pos.bot_en   = (CMP_W'(out_row_r) + CMP_W'(1) < CMP_W'(h_eff));
    pos.left_en  = (out_col_r != '0);
    pos.right_en = (CMP_W'(out_col_r) + CMP_W'(1) < CMP_W'(w_eff));
    pos.row      = out_row_r;
    pos.col      = out_col_r;
    pos.last     = last;
  end
  assign last = !pos.bot_en && !pos.right_en;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (cfg_hit) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (upd) begin
      if (col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + IN_ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (emit) begin
        if (last) begin
          // image done: restart the raster
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (!pos.right_en) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // ---------------------------------------------------------------- line memory
  always_ff @(posedge clk) begin
    if (upd) begin
      line_rd_r <= line_mem[in_col_r];
    end
    if (s1_vld_r) begin
      line_mem[s1_addr_r] <= {center_in, s1_samp_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      s1_emit_r <= emit;
      s1_addr_r <= in_col_r;
      s1_samp_r <= samp;
      s1_pos_r  <= pos;
      // the write of the item ahead lands on this edge: read returns stale data
      s1_fwd_r  <= s1_vld_r && (s1_addr_r == in_col_r);
    end
    if (s1_vld_r) begin
      fwd_above_r  <= center_in;
      fwd_center_r <= s1_samp_r;
    end
  end

  assign above_in  = s1_fwd_r ? fwd_above_r  : line_rd_r[PIX_W +: PIX_W];
  assign center_in = s1_fwd_r ? fwd_center_r : line_rd_r[0 +: PIX_W];

  // ---------------------------------------------------------------- window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (s1_vld_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= above_in;
      win_r[1][2] <= center_in;
      win_r[2][2] <= s1_samp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_pos_r <= s1_pos_r;
    end
  end

  // ---------------------------------------------------------------- sum
  assign row_en = {s2_pos_r.bot_en, 1'b1, s2_pos_r.top_en};
  assign col_en = {s2_pos_r.right_en, 1'b1, s2_pos_r.left_en};

  always_comb begin
    for (int k = 0; k < CH_FIELDS; k++) begin
      s2_sum[k] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (row_en[r] && col_en[c]) begin
            s2_sum[k] = s2_sum[k] + SUM_W'(win_r[r][c][k]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      s3_pos_r <= s2_pos_r;
      s3_sum_r <= s2_sum;
    end
  end

  // ---------------------------------------------------------------- divide by 3
  always_comb begin
    for (int k = 0; k < CH_FIELDS; k++) begin
      prod[k] = PROD_W'(s3_sum_r[k]) * PROD_W'(DIV3_MUL);
    end
    res.blur_ch0  = prod[0][DIV3_SHIFT +: BLUR_W];
    res.blur_ch1  = prod[1][DIV3_SHIFT +: BLUR_W];
    res.blur_ch2  = prod[2][DIV3_SHIFT +: BLUR_W];
    res.pixel_row = POS_W'(s3_pos_r.row);
    res.pixel_col = POS_W'(s3_pos_r.col);
    res.frame_end = s3_pos_r.last;
  end

  // ---------------------------------------------------------------- result queue
  assign out_valid = (fifo_cnt_r != '0);
  assign out_data  = fifo_mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    fifo_cnt_nxt = fifo_cnt_r;
    cred_nxt     = cred_r;
    if (s3_vld_r && !pop) begin
      fifo_cnt_nxt = fifo_cnt_r + FIFO_CNT_W'(1);
    end else if (!s3_vld_r && pop) begin
      fifo_cnt_nxt = fifo_cnt_r - FIFO_CNT_W'(1);
    end
    // reserve a queue slot for every result from the moment its item is taken
    if ((upd && emit) && !pop) begin
      cred_nxt = cred_r + FIFO_CNT_W'(1);
    end else if (!(upd && emit) && pop) begin
      cred_nxt = cred_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
      cred_r     <= '0;
    end else begin
      fifo_cnt_r <= fifo_cnt_nxt;
      cred_r     <= cred_nxt;
      if (s3_vld_r) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_vld_r) begin
      fifo_mem[wr_ptr_r] <= res;
    end
  end

endmodule

// ===== src/bb3_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the 3x3 box blur, bound to the top level.
`include "box_blur_3x3_stream_top_macros.svh"

module bb3_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input bb3_pkg::bb3_out_t  out_data,
  input logic               cfg_wr_en
);
  import bb3_pkg::*;

  logic             out_acc;
  logic             prv_vld_r;
  logic             prv_fe_r;
  logic [POS_W-1:0] prv_row_r;
  logic [POS_W-1:0] prv_col_r;

  assign out_acc = out_valid && !out_stall;

  // track the most recently accepted result transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prv_vld_r <= 1'b0;
      prv_fe_r  <= 1'b0;
      prv_row_r <= '0;
      prv_col_r <= '0;
    end else if (cfg_wr_en) begin
      prv_vld_r <= 1'b0;
      prv_fe_r  <= 1'b0;
    end else if (out_acc) begin
      prv_vld_r <= 1'b1;
      prv_fe_r  <= out_data.frame_end;
      prv_row_r <= out_data.pixel_row;
      prv_col_r <= out_data.pixel_col;
    end
  end

  `BB3_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `BB3_ASSERT_SAME(a_blur_range, clk, rst_n, out_valid, (out_data.blur_ch0 <= BLUR_W'(BLUR_MAX)) && (out_data.blur_ch1 <= BLUR_W'(BLUR_MAX)) && (out_data.blur_ch2 <= BLUR_W'(BLUR_MAX)), "blur value above range")
  `BB3_ASSERT_SAME(a_restart, clk, rst_n, out_valid && prv_vld_r && prv_fe_r, (out_data.pixel_row == '0) && (out_data.pixel_col == '0), "image did not restart at origin")
  `BB3_ASSERT_SAME(a_col_step, clk, rst_n, out_valid && prv_vld_r && !prv_fe_r && (out_data.pixel_row == prv_row_r), out_data.pixel_col == (prv_col_r + POS_W'(1)), "result column skipped or repeated")

endmodule

bind box_blur_3x3_stream_top bb3_checker u_bb3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_wr_en (cfg_wr_en)
);
